/* rtl/core/rdu_pkg.sv */
package rdu_pkg;

  localparam int FRAC_BITS = 14;
  localparam int RATIO_BITS = FRAC_BITS + 4;
  localparam int IN_W = 16;
  localparam int OUT_W = 18;
  localparam int NUM_W = IN_W + FRAC_BITS;
  localparam int SQ_W = 2 * FRAC_BITS + 2;
  localparam int COS_W = FRAC_BITS + 2;
  localparam int DIV_STEPS = NUM_W;
  localparam int SQRT_STEPS = FRAC_BITS + 1;
  localparam int ACC_W = 64;

  localparam logic [IN_W-1:0] DEFAULT_INDEX_RST = IN_W'(16384);
  localparam logic [RATIO_BITS-1:0] RATIO_MAX = {RATIO_BITS{1'b1}};
  localparam logic [COS_W-1:0] ONE = COS_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [IN_W-1:0] dir_x;
    logic signed [IN_W-1:0] dir_y;
    logic signed [IN_W-1:0] dir_z;
    logic signed [IN_W-1:0] normal_x;
    logic signed [IN_W-1:0] normal_y;
    logic signed [IN_W-1:0] normal_z;
    logic [IN_W-1:0] new_index;
  } rdu_vec_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] quo;
    logic [NUM_W-1:0] num;
    logic [IN_W-1:0] den;
    logic [COS_W-1:0] cos_i;
    logic big_i;
  } rdu_div_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [COS_W-1:0] root;
    logic [SQ_W-1:0] val;
    logic [RATIO_BITS-1:0] ratio;
    logic [COS_W-1:0] cos_i;
    logic fixed_t;
    logic [COS_W-1:0] fixed_cos;
    logic reflect;
  } rdu_sqrt_t;

endpackage

/* rtl/core/refraction_direction_unit.sv */
// Snell refraction vector unit, fully pipelined.
// Input: pulse start with the ray fields; busy is always low, so one ray
// can be transferred on every clock cycle.
// Output: done is high for one cycle with out_dir_x/y/z, new_index and
// total_reflect. The receiver cannot stall and needs none.
// The pipeline holds the restoring divider (one quotient bit per
// stage), the sine products, the square root (one root bit per stage)
// and the output products with the output register, in that order.
// Throughput is one ray per cycle.
// The configuration channel writes default_index with cfg_valid and
// cfg_ready; cfg_ready is always high. Write it only while no ray is in
// flight. Reset clears all valid bits and sets default_index to 1.0.
module refraction_direction_unit (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic signed [15:0] view_proj,
  input  logic inside_object,
  input  logic [15:0] material_density,
  input  logic [15:0] current_index,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [15:0] cfg_data,
  output logic done,
  output logic signed [17:0] out_dir_x,
  output logic signed [17:0] out_dir_y,
  output logic signed [17:0] out_dir_z,
  output logic [15:0] new_index,
  output logic total_reflect
);
  import rdu_pkg::*;

  logic [IN_W-1:0] default_index;
  rdu_vec_t in_vec, v1, v2;
  logic ok1, ok2, big1, refl2;
  logic [RATIO_BITS-1:0] r1, r2;
  logic [COS_W-1:0] c1, c2, ct2;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_index <= DEFAULT_INDEX_RST;
    end else if (cfg_valid && cfg_ready) begin
      default_index <= cfg_data;
    end
  end

  always_comb begin
    in_vec.dir_x = dir_x;
    in_vec.dir_y = dir_y;
    in_vec.dir_z = dir_z;
    in_vec.normal_x = normal_x;
    in_vec.normal_y = normal_y;
    in_vec.normal_z = normal_z;
    in_vec.new_index = inside_object ? default_index : material_density;
  end

  rdu_ratio u_ratio (
    .clk(clk), .rst(rst), .in_valid(start && !busy),
    .cur_index(current_index), .den(in_vec.new_index), .view_proj(view_proj),
    .in_vec(in_vec), .out_valid(ok1), .ratio(r1), .cos_i(c1), .big_i(big1),
    .out_vec(v1)
  );

  rdu_cos u_cos (
    .clk(clk), .rst(rst), .in_valid(ok1), .ratio(r1), .cos_i(c1),
    .big_i(big1), .in_vec(v1), .out_valid(ok2), .ratio_o(r2), .cos_i_o(c2),
    .cos_t(ct2), .reflect(refl2), .out_vec(v2)
  );

  rdu_combine u_combine (
    .clk(clk), .rst(rst), .in_valid(ok2), .ratio(r2), .cos_i(c2),
    .cos_t(ct2), .reflect(refl2), .in_vec(v2), .done(done),
    .out_dir_x(out_dir_x), .out_dir_y(out_dir_y), .out_dir_z(out_dir_z),
    .new_index(new_index), .total_reflect(total_reflect)
  );
endmodule

/* rtl/core/rdu_ratio.sv */
module rdu_ratio (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [rdu_pkg::IN_W-1:0] cur_index,
  input  logic [rdu_pkg::IN_W-1:0] den,
  input  logic signed [rdu_pkg::IN_W-1:0] view_proj,
  input  rdu_pkg::rdu_vec_t in_vec,
  output logic out_valid,
  output logic [rdu_pkg::RATIO_BITS-1:0] ratio,
  output logic [rdu_pkg::COS_W-1:0] cos_i,
  output logic big_i,
  output rdu_pkg::rdu_vec_t out_vec
);
  import rdu_pkg::*;

  rdu_div_t st [DIV_STEPS+1];
  rdu_vec_t vec [DIV_STEPS+1];
  logic [DIV_STEPS:0] vld;

  always_comb begin
    logic [COS_W-1:0] a;
    a = view_proj[IN_W-1] ? COS_W'(-$signed({view_proj[IN_W-1], view_proj}))
                          : COS_W'(view_proj);
    st[0].rem = '0;
    st[0].quo = '0;
    st[0].num = {cur_index, FRAC_BITS'(0)};
    st[0].den = den;
    st[0].cos_i = a;
    st[0].big_i = (a >= ONE);
    vec[0] = in_vec;
    vld[0] = in_valid;
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [NUM_W:0] trial;
    rdu_div_t nx;
    always_comb begin
      nx = st[i];
      trial = {st[i].rem, st[i].num[NUM_W-1-i]};
      if (trial >= {{(NUM_W+1-IN_W){1'b0}}, st[i].den}) begin
        nx.rem = NUM_W'(trial - {{(NUM_W+1-IN_W){1'b0}}, st[i].den});
        nx.quo = {st[i].quo[NUM_W-2:0], 1'b1};
      end else begin
        nx.rem = NUM_W'(trial);
        nx.quo = {st[i].quo[NUM_W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      st[i+1] <= nx;
      vec[i+1] <= vec[i];
    end
  end

  always_comb begin
    rdu_div_t f;
    f = st[DIV_STEPS];
    if (f.den == '0 || f.quo > NUM_W'(RATIO_MAX)) begin
      ratio = RATIO_MAX;
    end else begin
      ratio = f.quo[RATIO_BITS-1:0];
    end
    cos_i = f.cos_i;
    big_i = f.big_i;
    out_vec = vec[DIV_STEPS];
    out_valid = vld[DIV_STEPS];
  end
endmodule

/* rtl/core/rdu_cos.sv */
module rdu_cos (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [rdu_pkg::RATIO_BITS-1:0] ratio,
  input  logic [rdu_pkg::COS_W-1:0] cos_i,
  input  logic big_i,
  input  rdu_pkg::rdu_vec_t in_vec,
  output logic out_valid,
  output logic [rdu_pkg::RATIO_BITS-1:0] ratio_o,
  output logic [rdu_pkg::COS_W-1:0] cos_i_o,
  output logic [rdu_pkg::COS_W-1:0] cos_t,
  output logic reflect,
  output rdu_pkg::rdu_vec_t out_vec
);
  import rdu_pkg::*;

  localparam int R2_W = 2 * RATIO_BITS - FRAC_BITS;

  logic v1, v2;
  logic [FRAC_BITS:0] om1;
  logic [R2_W-1:0] r2_1;
  logic [RATIO_BITS-1:0] ratio1, ratio2;
  logic [COS_W-1:0] ci1, ci2;
  logic big1, big2;
  logic [R2_W+FRAC_BITS:0] s2_2;
  rdu_vec_t vec1, vec2;
  rdu_sqrt_t sq [SQRT_STEPS+1];
  rdu_vec_t sv [SQRT_STEPS+1];
  logic [SQRT_STEPS:0] svld;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
    om1 <= (FRAC_BITS+1)'(({{COS_W{1'b0}}, ONE} * {{COS_W{1'b0}}, ONE}
           - {{COS_W{1'b0}}, cos_i} * {{COS_W{1'b0}}, cos_i}) >> FRAC_BITS);
    r2_1 <= R2_W'(({{RATIO_BITS{1'b0}}, ratio} * {{RATIO_BITS{1'b0}}, ratio}) >> FRAC_BITS);
    ratio1 <= ratio;
    ci1 <= cos_i;
    big1 <= big_i;
    vec1 <= in_vec;
    s2_2 <= (R2_W+FRAC_BITS+1)'(({{(FRAC_BITS+1){1'b0}}, r2_1}
            * {{R2_W{1'b0}}, om1}) >> FRAC_BITS);
    ratio2 <= ratio1;
    ci2 <= ci1;
    big2 <= big1;
    vec2 <= vec1;
  end

  always_comb begin
    sq[0].rem = '0;
    sq[0].root = '0;
    sq[0].ratio = ratio2;
    sq[0].cos_i = ci2;
    sq[0].fixed_t = 1'b1;
    sq[0].reflect = 1'b0;
    sq[0].val = '0;
    if (big2) begin
      sq[0].fixed_cos = ONE;
    end else if (s2_2 >= (R2_W+FRAC_BITS+1)'(ONE)) begin
      sq[0].fixed_cos = '0;
      sq[0].reflect = 1'b1;
    end else begin
      sq[0].fixed_cos = '0;
      sq[0].fixed_t = 1'b0;
      sq[0].val = SQ_W'((ONE - COS_W'(s2_2)) ) << FRAC_BITS;
    end
    sv[0] = vec2;
    svld[0] = v2;
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    logic [SQ_W+1:0] trial;
    logic [SQ_W+1:0] rem2;
    rdu_sqrt_t nx;
    always_comb begin
      nx = sq[i];
      rem2 = {sq[i].rem, sq[i].val[SQ_W-1:SQ_W-2]};
      trial = {{(SQ_W+2-COS_W-2){1'b0}}, sq[i].root, 2'b01};
      nx.val = {sq[i].val[SQ_W-3:0], 2'b00};
      if (rem2 >= trial) begin
        nx.rem = SQ_W'(rem2 - trial);
        nx.root = {sq[i].root[COS_W-2:0], 1'b1};
      end else begin
        nx.rem = SQ_W'(rem2);
        nx.root = {sq[i].root[COS_W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        svld[i+1] <= 1'b0;
      end else begin
        svld[i+1] <= svld[i];
      end
      sq[i+1] <= nx;
      sv[i+1] <= sv[i];
    end
  end

  always_comb begin
    rdu_sqrt_t f;
    f = sq[SQRT_STEPS];
    out_valid = svld[SQRT_STEPS];
    ratio_o = f.ratio;
    cos_i_o = f.cos_i;
    cos_t = f.fixed_t ? f.fixed_cos : f.root;
    reflect = f.reflect;
    out_vec = sv[SQRT_STEPS];
  end
endmodule

/* rtl/core/rdu_combine.sv */
module rdu_combine (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [rdu_pkg::RATIO_BITS-1:0] ratio,
  input  logic [rdu_pkg::COS_W-1:0] cos_i,
  input  logic [rdu_pkg::COS_W-1:0] cos_t,
  input  logic reflect,
  input  rdu_pkg::rdu_vec_t in_vec,
  output logic done,
  output logic signed [rdu_pkg::OUT_W-1:0] out_dir_x,
  output logic signed [rdu_pkg::OUT_W-1:0] out_dir_y,
  output logic signed [rdu_pkg::OUT_W-1:0] out_dir_z,
  output logic [rdu_pkg::IN_W-1:0] new_index,
  output logic total_reflect
);
  import rdu_pkg::*;

  localparam int A_W = IN_W + FRAC_BITS + 3;
  localparam int T_W = IN_W + COS_W + 1;
  localparam int P_W = A_W + RATIO_BITS + 1;
  localparam int D_W = P_W + 2;

  logic v1, v2, v3;
  logic signed [A_W-1:0] a1 [3];
  logic signed [T_W-1:0] t1 [3];
  logic signed [T_W-1:0] t2 [3];
  logic signed [P_W-1:0] p2 [3];
  logic signed [D_W-1:0] d3 [3];
  logic [RATIO_BITS-1:0] ratio1;
  logic [IN_W-1:0] ni1, ni2, ni3;
  logic rf1, rf2, rf3;
  logic signed [IN_W-1:0] dv [3];
  logic signed [IN_W-1:0] nv [3];
  logic signed [OUT_W-1:0] sat [3];

  assign dv[0] = in_vec.dir_x;
  assign dv[1] = in_vec.dir_y;
  assign dv[2] = in_vec.dir_z;
  assign nv[0] = in_vec.normal_x;
  assign nv[1] = in_vec.normal_y;
  assign nv[2] = in_vec.normal_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    ratio1 <= ratio;
    ni1 <= in_vec.new_index;
    ni2 <= ni1;
    ni3 <= ni2;
    rf1 <= reflect;
    rf2 <= rf1;
    rf3 <= rf2;
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    always_ff @(posedge clk) begin
      a1[k] <= (A_W'(dv[k]) <<< FRAC_BITS)
             + A_W'(nv[k]) * A_W'($signed({1'b0, cos_i}));
      t1[k] <= T_W'(nv[k]) * T_W'($signed({1'b0, cos_t}));
      p2[k] <= P_W'(a1[k]) * P_W'($signed({1'b0, ratio1}));
      t2[k] <= t1[k];
      d3[k] <= D_W'(p2[k]) - (D_W'(t2[k]) <<< FRAC_BITS);
    end
    always_comb begin
      logic signed [D_W-1:0] s;
      s = d3[k] >>> (2 * FRAC_BITS);
      if (s > D_W'(2 ** (OUT_W - 1) - 1)) begin
        sat[k] = {1'b0, {(OUT_W-1){1'b1}}};
      end else if (s < -D_W'(2 ** (OUT_W - 1))) begin
        sat[k] = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        sat[k] = OUT_W'(s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
    out_dir_x <= sat[0];
    out_dir_y <= sat[1];
    out_dir_z <= sat[2];
    new_index <= ni3;
    total_reflect <= rf3;
  end
endmodule

/* tb/sv/testbench.sv */
module testbench;
  import rdu_pkg::*;

  localparam int LATENCY = 51;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_RAYS = 1700;

  typedef struct {
    logic signed [15:0] dx, dy, dz, nx, ny, nz, vp;
    logic in_obj;
    logic [15:0] density, cur;
  } ray_t;

  typedef struct {
    logic signed [17:0] ox, oy, oz;
    logic [15:0] nidx;
    logic refl;
  } refr_t;

  typedef struct {
    ray_t ray;
    bit known;
    refr_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic signed [15:0] view_proj = '0;
  logic inside_object = 1'b0;
  logic [15:0] material_density = '0, current_index = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;
  logic done;
  logic signed [17:0] out_dir_x, out_dir_y, out_dir_z;
  logic [15:0] new_index;
  logic total_reflect;

  refr_t expected_dirs[$];
  logic [15:0] model_default_index = DEFAULT_INDEX_RST;
  int mismatches = 0;
  int refr_seen = 0;
  int reflect_seen = 0;
  int idle_cycles = 0;
  bit timed_out = 0;

  refraction_direction_unit dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [17:0] refract_axis(longint d, longint n, longint ci,
                                                     longint ct, longint ratio);
    longint a, v;
    a = (d * 16384 + n * ci) * ratio - n * ct * 16384;
    v = a >>> 28;
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[17:0];
  endfunction

  function automatic refr_t refract(ray_t r);
    refr_t e;
    longint unsigned newi, ratio, ci, ct, om, r2, s2;
    newi = 64'(r.in_obj ? model_default_index : r.density);
    e.refl = 1'b0;
    if (newi == 0) ratio = 262143;
    else begin
      ratio = (longint'(r.cur) << 14) / newi;
      if (ratio > 262143) ratio = 262143;
    end
    ci = (r.vp < 0) ? -longint'(r.vp) : longint'(r.vp);
    if (ci >= 16384) ct = 16384;
    else begin
      om = (longint'(16384) * 16384 - ci * ci) >> 14;
      r2 = (ratio * ratio) >> 14;
      s2 = (r2 * om) >> 14;
      if (s2 >= 16384) begin
        ct = 0;
        e.refl = 1'b1;
      end else begin
        ct = int_sqrt((16384 - s2) << 14);
      end
    end
    e.ox = refract_axis(longint'(r.dx), longint'(r.nx), ci, ct, ratio);
    e.oy = refract_axis(longint'(r.dy), longint'(r.ny), ci, ct, ratio);
    e.oz = refract_axis(longint'(r.dz), longint'(r.nz), ci, ct, ratio);
    e.nidx = newi[15:0];
    return e;
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    int pick;
    pick = $urandom_range(0, 9);
    r.dx = 16'($urandom); r.dy = 16'($urandom); r.dz = 16'($urandom);
    r.nx = 16'($urandom); r.ny = 16'($urandom); r.nz = 16'($urandom);
    r.vp = 16'($urandom);
    r.in_obj = 1'($urandom);
    r.density = 16'($urandom);
    r.cur = 16'($urandom);
    if (pick < 6) begin
      // Physical-looking rays: unit-scale vectors and indices near one.
      r.dx = 16'($signed($urandom_range(0, 32768)) - 16384);
      r.dy = 16'($signed($urandom_range(0, 32768)) - 16384);
      r.dz = 16'($signed($urandom_range(0, 32768)) - 16384);
      r.nx = 16'($signed($urandom_range(0, 32768)) - 16384);
      r.ny = 16'($signed($urandom_range(0, 32768)) - 16384);
      r.nz = 16'($signed($urandom_range(0, 32768)) - 16384);
      r.vp = 16'($signed($urandom_range(0, 32768)) - 16384);
      r.density = 16'($urandom_range(16384, 40000));
      r.cur = 16'($urandom_range(16384, 40000));
    end else if (pick == 6) begin
      r.density = 16'($urandom_range(0, 3));
    end
    return r;
  endfunction

  task automatic send_ray(ray_t r);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
          (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
    normal_x <= r.nx; normal_y <= r.ny; normal_z <= r.nz;
    view_proj <= r.vp;
    inside_object <= r.in_obj;
    material_density <= r.density;
    current_index <= r.cur;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_and_settle();
    start <= 1'b0;
    while (expected_dirs.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_default_index(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model_default_index = v;
  endtask

  // A ray is pushed when its transfer edge is seen, so the queue order follows the DUT.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      ray_t r;
      r.dx = dir_x; r.dy = dir_y; r.dz = dir_z;
      r.nx = normal_x; r.ny = normal_y; r.nz = normal_z;
      r.vp = view_proj; r.in_obj = inside_object;
      r.density = material_density; r.cur = current_index;
      expected_dirs.push_back(refract(r));
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      refr_t e;
      refr_seen++;
      if (total_reflect) reflect_seen++;
      if (expected_dirs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        e = expected_dirs.pop_front();
        if (e.ox !== out_dir_x || e.oy !== out_dir_y || e.oz !== out_dir_z ||
            e.nidx !== new_index || e.refl !== total_reflect) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d idx %0d tr %0d, got %0d %0d %0d idx %0d tr %0d",
                     e.ox, e.oy, e.oz, e.nidx, e.refl, out_dir_x, out_dir_y, out_dir_z,
                     new_index, total_reflect);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      timed_out = 1;
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic row_t mk(logic signed [15:0] dx, dy, dz, nx, ny, nz, vp,
                              logic ins, logic [15:0] den, cur,
                              bit known = 0, logic signed [17:0] ox = 0, oy = 0, oz = 0,
                              logic [15:0] ni = 0, logic tr = 0);
    row_t w;
    w.ray.dx = dx; w.ray.dy = dy; w.ray.dz = dz;
    w.ray.nx = nx; w.ray.ny = ny; w.ray.nz = nz;
    w.ray.vp = vp; w.ray.in_obj = ins; w.ray.density = den; w.ray.cur = cur;
    w.known = known;
    w.res.ox = ox; w.res.oy = oy; w.res.oz = oz; w.res.nidx = ni; w.res.refl = tr;
    return w;
  endfunction

  initial begin
    row_t rows[$];
    refr_t p;
    logic [15:0] settings[4] = '{16'd0, 16'hFFFF, 16'd24576, 16'd1};
    rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 16384, 16384, 1, 0, 0, 0, 16384, 1));
    rows.push_back(mk(16384, 0, 0, 0, 0, 16384, 16384, 0, 16384, 16384,
                      1, 16384, 0, 0, 16384, 0));
    rows.push_back(mk(16384, 0, 0, 0, 0, 0, 0, 1, 0, 16384, 1, 16384, 0, 0, 16384, 1));
    rows.push_back(mk(32767, 32767, 32767, 0, 0, 0, -32768, 0, 0, 65535,
                      1, 131071, 131071, 131071, 0, 0));
    rows.push_back(mk(-32768, -32768, -32768, 0, 0, 0, 0, 0, 1, 65535,
                      1, -131072, -131072, -131072, 1, 1));
    rows.push_back(mk(16384, 0, 0, 16384, 0, 0, 0, 0, 16384, 32767));
    rows.push_back(mk(11585, 0, -11585, 0, 0, 16384, -11585, 0, 24576, 16384));
    rows.push_back(mk(11585, 0, -11585, 0, 0, 16384, -11585, 0, 16384, 24576));
    rows.push_back(mk(-32768, 32767, 100, 32767, -32768, -1, 16383, 0, 65535, 0));
    rows.push_back(mk(5000, -5000, 9000, -16384, 16384, 0, 16384, 1, 40000, 20000));
    rows.push_back(mk(1, -1, 0, 1, -1, 0, 1, 1, 1, 1));
    rows.push_back(mk(-16384, 16384, 0, 16384, 0, -16384, -16384, 0, 65535, 65535));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      if (rows[i].known) begin
        p = refract(rows[i].ray);
        if (p.ox !== rows[i].res.ox || p.oy !== rows[i].res.oy ||
            p.oz !== rows[i].res.oz || p.nidx !== rows[i].res.nidx ||
            p.refl !== rows[i].res.refl) begin
          mismatches++;
          if (mismatches <= 10) $display("directed row %0d: table and predictor disagree", i);
        end
      end
      send_ray(rows[i].ray);
    end
    drain_and_settle();

    for (int phase = 0; phase < 5; phase++) begin
      write_default_index(phase < 4 ? settings[phase] : 16'($urandom));
      rows.delete();
      for (int k = 0; k < 8; k++) rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      foreach (rows[i]) begin
        rows[i].ray = random_ray();
        rows[i].ray.in_obj = 1'b1;
        send_ray(rows[i].ray);
      end
      for (int k = 0; k < RANDOM_RAYS / 5; k++) send_ray(random_ray());
      drain_and_settle();
    end

    $display("Covered %0d refracted rays, %0d with total reflection,", refr_seen, reflect_seen);
    $display("across six default index settings including zero and full scale.");
    if (mismatches == 0 && !timed_out) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
